// File: design/rpl_pkg.sv
// ----------------------------------------------------------------------------
// rpl_pkg: shared types and codes for the ring protection link event block
// Beat payloads, per-slot flag record, the scan states and the command, port, node and packet codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rpl_pkg;

  // Command codes of an input beat.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_UP   = 2'd1;
  localparam logic [1:0] CMD_DOWN = 2'd2;

  // Port states.
  localparam logic ST_BLOCK = 1'b0;
  localparam logic ST_FWD   = 1'b1;

  // Node states.
  localparam logic [1:0] ND_IDLE = 2'd0;
  localparam logic [1:0] ND_PRE  = 2'd1;
  localparam logic [1:0] ND_DOWN = 2'd2;

  // Packet kinds.
  localparam logic PKT_FLUSH     = 1'b0;
  localparam logic PKT_LINK_DOWN = 1'b1;

  // Hard ceiling on the slot table.
  localparam int unsigned MAX_SLOTS = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } rpl_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  ring_slot;
    logic        ring_enable;
    logic        node_is_master;
    logic [31:0] port_a_id;
    logic [31:0] port_b_id;
    logic        port_a_init;
    logic        port_b_init;
    logic [1:0]  node_init;
    logic [31:0] event_port;
  } rpl_in_t;

  typedef struct packed {
    logic        matched;
    logic [4:0]  slot_out;
    logic        port_a_state;
    logic        port_b_state;
    logic [1:0]  node_state;
    logic        send_packet;
    logic        packet_kind;
    logic [31:0] send_port;
    logic        last;
  } rpl_out_t;

  // Everything a slot holds apart from its two port identifiers.
  typedef struct packed {
    logic       en;
    logic       master;
    logic       sa;
    logic       sb;
    logic [1:0] node;
  } rpl_flags_t;

endpackage

`default_nettype wire

// File: design/rpl_cell.sv
// ----------------------------------------------------------------------------
// rpl_cell: one ring slot record in the rotating slot chain
// Holds a slot; on load takes a new record and, on shift, the record of its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module rpl_cell
  import rpl_pkg::*;
#(
  parameter int unsigned PW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire rpl_flags_t    flags_in_i,
  input  wire logic [PW-1:0] pa_in_i,
  input  wire logic [PW-1:0] pb_in_i,
  input  wire logic          load_i,
  input  wire rpl_flags_t    load_flags_i,
  input  wire logic [PW-1:0] load_pa_i,
  input  wire logic [PW-1:0] load_pb_i,
  output rpl_flags_t         flags_o,
  output logic      [PW-1:0] pa_o,
  output logic      [PW-1:0] pb_o
);

  rpl_flags_t    flags_q;
  logic [PW-1:0] pa_q;
  logic [PW-1:0] pb_q;

  // Only the enable bit matters after reset; the rest is cleared alongside it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (load_i) begin
      flags_q <= load_flags_i;
    end else if (shift_i) begin
      flags_q <= flags_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pa_q <= load_pa_i;
      pb_q <= load_pb_i;
    end else if (shift_i) begin
      pa_q <= pa_in_i;
      pb_q <= pb_in_i;
    end
  end

  assign flags_o = flags_q;
  assign pa_o    = pa_q;
  assign pb_o    = pb_q;

endmodule

`default_nettype wire

// File: design/rpl_rules.sv
// ----------------------------------------------------------------------------
// rpl_rules: ring rules applied to the slot at the head of the chain
// Decides the match, the new port and node states and the packet to send.
// ----------------------------------------------------------------------------
`default_nettype none

module rpl_rules
  import rpl_pkg::*;
#(
  parameter int unsigned PW = 32
) (
  input  wire rpl_flags_t    flags_i,
  input  wire logic [PW-1:0] pa_i,
  input  wire logic [PW-1:0] pb_i,
  input  wire logic [PW-1:0] ev_i,
  input  wire logic          link_down_i,
  output logic               hit_o,
  output rpl_flags_t         flags_o,
  output logic               send_o,
  output logic               kind_o,
  output logic      [PW-1:0] sport_o
);

  logic on0;
  logic on1;

  assign on0   = (ev_i == pa_i);
  assign on1   = (ev_i == pb_i);
  assign hit_o = flags_i.en && (on0 || on1);

  always_comb begin
    flags_o = flags_i;
    send_o  = 1'b0;
    kind_o  = PKT_FLUSH;
    sport_o = '0;
    if (!link_down_i) begin
      case ({flags_i.sa, flags_i.sb})
        {ST_BLOCK, ST_BLOCK}: begin
          if (flags_i.master) begin
            if (on0) flags_o.sa = ST_FWD;
            else     flags_o.sb = ST_FWD;
          end else begin
            flags_o.node = ND_PRE;
          end
        end
        {ST_FWD, ST_BLOCK}: begin
          if (!on0 && !flags_i.master) flags_o.node = ND_PRE;
        end
        {ST_BLOCK, ST_FWD}: begin
          if (on0) begin
            if (flags_i.master) begin
              flags_o.sa = ST_FWD;
              flags_o.sb = ST_BLOCK;
            end else begin
              flags_o.node = ND_PRE;
            end
          end
        end
        default: begin
          if (flags_i.master) begin
            flags_o.sa = ST_FWD;
            flags_o.sb = ST_BLOCK;
          end else begin
            flags_o.node = ND_PRE;
            flags_o.sa   = ST_BLOCK;
            flags_o.sb   = ST_BLOCK;
          end
        end
      endcase
    end else begin
      case ({flags_i.sa, flags_i.sb})
        {ST_FWD, ST_BLOCK}: begin
          if (on0) begin
            flags_o.sa = ST_BLOCK;
            send_o     = 1'b1;
            sport_o    = pb_i;
            if (flags_i.master) begin
              flags_o.sb = ST_FWD;
              kind_o     = PKT_FLUSH;
            end else begin
              kind_o = PKT_LINK_DOWN;
            end
          end else if (!flags_i.master) begin
            send_o  = 1'b1;
            kind_o  = PKT_LINK_DOWN;
            sport_o = pa_i;
          end
        end
        {ST_BLOCK, ST_FWD}: begin
          if (!on0) begin
            flags_o.sb = ST_BLOCK;
            send_o     = 1'b1;
            sport_o    = pa_i;
            if (flags_i.master) begin
              kind_o = PKT_FLUSH;
            end else begin
              flags_o.node = ND_DOWN;
              kind_o       = PKT_LINK_DOWN;
            end
          end
        end
        {ST_FWD, ST_FWD}: begin
          send_o = 1'b1;
          if (on0) begin
            sport_o    = pb_i;
            flags_o.sa = ST_BLOCK;
            if (flags_i.master) begin
              flags_o.sb = ST_FWD;
              kind_o     = PKT_FLUSH;
            end else begin
              flags_o.node = ND_DOWN;
              kind_o       = PKT_LINK_DOWN;
            end
          end else begin
            sport_o    = pa_i;
            flags_o.sb = ST_BLOCK;
            if (flags_i.master) begin
              flags_o.sa = ST_FWD;
              kind_o     = PKT_FLUSH;
            end else begin
              flags_o.node = ND_DOWN;
              kind_o       = PKT_LINK_DOWN;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/ring_protection_link_event.sv
// ----------------------------------------------------------------------------
// ring_protection_link_event: ring slot table with link up/down handling
// Slot records rotate through a chain of cells past one rules unit.
// ----------------------------------------------------------------------------
// A load beat, a beat with an unknown command and a link event beat while the
// service is off each give one result beat. The block moves to its flush
// state, registers that beat there once the output has room, and then returns
// to idle to take the next input beat. A link event beat with the service on
// rotates the whole slot chain once past the rules unit at its head, one slot
// per cycle while no match waits, whether or not any slot matches. That is
// SLOT_COUNT shifts (32 by default); the final beat is then registered in the
// flush state, and the next input beat can be taken once the block is back in
// idle. A match waits while an earlier result beat is still stalled at the
// output, so output stalls lengthen the scan. Matching slots come out in slot
// order, the last one flagged; if none matches, one unmatched beat closes the
// item. The block takes a new beat only when idle.
`default_nettype none

module ring_protection_link_event
  import rpl_pkg::*;
#(
  parameter int unsigned DOMAIN_COUNT     = 4,
  parameter int unsigned RINGS_PER_DOMAIN = 8,
  parameter int unsigned PORT_ID_BITS     = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    cfg_we_i,
  input  wire logic    cfg_wdata_i,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire rpl_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output rpl_out_t     out_data_o
);

  localparam int unsigned RAW_SLOTS  = DOMAIN_COUNT * RINGS_PER_DOMAIN;
  localparam int unsigned SLOT_COUNT = (RAW_SLOTS > MAX_SLOTS) ? MAX_SLOTS : RAW_SLOTS;
  localparam int unsigned SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned PW         = PORT_ID_BITS;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

  rpl_state_e state_q, state_d;

  logic          svc_en_q;
  logic [SLOT_W-1:0] idx_q;
  logic [PW-1:0] ev_q;
  logic          down_q;
  rpl_out_t      pend_q;
  logic          pend_valid_q;
  logic          out_valid_q;
  rpl_out_t      out_q;

  logic       in_acc;
  logic       is_load;
  logic       is_event;
  logic       load_ok;
  logic [1:0] node_sat;
  rpl_flags_t load_flags;
  rpl_out_t   load_res;

  rpl_flags_t    cell_flags [SLOT_COUNT];
  logic [PW-1:0] cell_pa    [SLOT_COUNT];
  logic [PW-1:0] cell_pb    [SLOT_COUNT];

  logic          hit;
  rpl_flags_t    head_flags;
  logic          send;
  logic          kind;
  logic [PW-1:0] sport;
  rpl_out_t      hit_res;

  logic     out_free;
  logic     advance;
  logic     shift_en;
  logic     push;
  rpl_out_t push_data;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_load  = (in_data_i.cmd == CMD_LOAD);
  assign is_event = (in_data_i.cmd == CMD_UP || in_data_i.cmd == CMD_DOWN) && svc_en_q;
  assign load_ok  = ({1'b0, in_data_i.ring_slot} < 6'(SLOT_COUNT));
  assign node_sat = (in_data_i.node_init > ND_DOWN) ? ND_DOWN : in_data_i.node_init;

  always_comb begin
    load_flags.en     = in_data_i.ring_enable;
    load_flags.master = in_data_i.node_is_master;
    load_flags.sa     = in_data_i.port_a_init;
    load_flags.sb     = in_data_i.port_b_init;
    load_flags.node   = node_sat;
  end

  // A load past the table writes nothing and reports itself unmatched.
  always_comb begin
    load_res          = '0;
    load_res.slot_out = in_data_i.ring_slot;
    if (load_ok) begin
      load_res.matched      = 1'b1;
      load_res.port_a_state = in_data_i.port_a_init;
      load_res.port_b_state = in_data_i.port_b_init;
      load_res.node_state   = node_sat;
    end
  end

  // The chain rotates toward cell 0; the updated head record re-enters at
  // the far end, so after SLOT_COUNT shifts every slot is home again.
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    rpl_flags_t    nb_flags;
    logic [PW-1:0] nb_pa;
    logic [PW-1:0] nb_pb;

    if (i == SLOT_COUNT - 1) begin : g_tail
      assign nb_flags = hit ? head_flags : cell_flags[0];
      assign nb_pa    = cell_pa[0];
      assign nb_pb    = cell_pb[0];
    end else begin : g_body
      assign nb_flags = cell_flags[i+1];
      assign nb_pa    = cell_pa[i+1];
      assign nb_pb    = cell_pb[i+1];
    end

    rpl_cell #(
      .PW(PW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift_en),
      .flags_in_i  (nb_flags),
      .pa_in_i     (nb_pa),
      .pb_in_i     (nb_pb),
      .load_i      (in_acc && is_load && load_ok && (in_data_i.ring_slot == 5'(i))),
      .load_flags_i(load_flags),
      .load_pa_i   (in_data_i.port_a_id[PW-1:0]),
      .load_pb_i   (in_data_i.port_b_id[PW-1:0]),
      .flags_o     (cell_flags[i]),
      .pa_o        (cell_pa[i]),
      .pb_o        (cell_pb[i])
    );
  end

  rpl_rules #(
    .PW(PW)
  ) u_rules (
    .flags_i    (cell_flags[0]),
    .pa_i       (cell_pa[0]),
    .pb_i       (cell_pb[0]),
    .ev_i       (ev_q),
    .link_down_i(down_q),
    .hit_o      (hit),
    .flags_o    (head_flags),
    .send_o     (send),
    .kind_o     (kind),
    .sport_o    (sport)
  );

  always_comb begin
    hit_res              = '0;
    hit_res.matched      = 1'b1;
    hit_res.slot_out     = 5'(idx_q);
    hit_res.port_a_state = head_flags.sa;
    hit_res.port_b_state = head_flags.sb;
    hit_res.node_state   = head_flags.node;
    hit_res.send_packet  = send;
    hit_res.packet_kind  = kind;
    hit_res.send_port    = 32'(sport);
  end

  assign out_free = !out_valid_q || !out_stall_i;
  // A match pushes the previous pending beat out, so it waits for room.
  assign advance  = !hit || !pend_valid_q || out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = (!is_load && is_event) ? ST_SCAN : ST_FLUSH;
      end
      ST_SCAN: begin
        if (advance && idx_q == LAST_IDX) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    shift_en   = 1'b0;
    push       = 1'b0;
    push_data  = pend_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_SCAN: begin
        shift_en       = advance;
        push           = advance && hit && pend_valid_q;
        push_data.last = 1'b0;
      end
      ST_FLUSH: begin
        push = out_free;
        if (!pend_valid_q) push_data = '0;
        push_data.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      svc_en_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) svc_en_q <= cfg_wdata_i;

      if (in_acc) begin
        idx_q        <= '0;
        pend_valid_q <= is_load;
      end else if (shift_en) begin
        idx_q <= idx_q + SLOT_W'(1);
        if (hit) pend_valid_q <= 1'b1;
      end else if (state_q == ST_FLUSH && out_free) begin
        pend_valid_q <= 1'b0;
      end

      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ev_q   <= in_data_i.event_port[PW-1:0];
      down_q <= (in_data_i.cmd == CMD_DOWN);
      pend_q <= load_res;
    end else if (shift_en && hit) begin
      pend_q <= hit_res;
    end
    if (push) out_q <= push_data;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: design/rpl_checker.sv
// ----------------------------------------------------------------------------
// rpl_checker: port-level checks for the ring protection link event block
// Watches the beats on both channels and the shape of each result.
// ----------------------------------------------------------------------------
`default_nettype none

module rpl_checker
  import rpl_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire rpl_out_t out_data_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i
);

  // A held result must not change while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // The block works on one input beat at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a beat");

  // An unmatched result always stands alone, so it closes its item.
  a_unmatched_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.matched |-> out_data_o.last)
    else $error("unmatched result without last");

  // Packet fields are quiet when no packet is sent.
  a_no_packet_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.send_packet |->
      out_data_o.packet_kind == PKT_FLUSH && out_data_o.send_port == 32'd0)
    else $error("packet fields set without a packet");

endmodule

bind ring_protection_link_event rpl_checker u_rpl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_data_o (out_data_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i)
);

`default_nettype wire

// File: bench/tb_ring_protection_link_event.sv
// ----------------------------------------------------------------------------
// tb_ring_protection_link_event: self-checking bench for the ring slot table
// Loads ring slots and sends link up/down beats, predicts every report beat
// from a local copy of the slot table, and checks the reports in order while
// both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ring_protection_link_event
  import rpl_pkg::*;
();

  localparam int unsigned SLOT_COUNT  = 32;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic [1:0]  CMD_RSVD    = 2'd3;
  localparam logic [1:0]  NODE_RSVD   = 2'd3;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     cfg_we_i;
  logic     cfg_wdata_i;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  rpl_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  rpl_out_t out_data_o;

  ring_protection_link_event dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Local copy of the slot table and the service enable.
  logic        tbl_en     [SLOT_COUNT] = '{default: 1'b0};
  logic        tbl_master [SLOT_COUNT] = '{default: 1'b0};
  logic [31:0] tbl_pa     [SLOT_COUNT] = '{default: 32'd0};
  logic [31:0] tbl_pb     [SLOT_COUNT] = '{default: 32'd0};
  logic        tbl_sa     [SLOT_COUNT] = '{default: 1'b0};
  logic        tbl_sb     [SLOT_COUNT] = '{default: 1'b0};
  logic [1:0]  tbl_node   [SLOT_COUNT] = '{default: ND_IDLE};
  logic        svc_en;

  rpl_in_t     cmd_fifo[$];
  rpl_out_t    report_fifo[$];
  rpl_out_t    want_report;

  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned errors          = 0;
  int unsigned beats_taken     = 0;
  int unsigned reports_seen    = 0;
  int unsigned reports_matched = 0;
  int unsigned quiet_cycles    = 0;
  bit          beat_taken;

  // Applies one command beat to the local table and queues its report beats.
  task automatic ring_rules(input rpl_in_t b);
    rpl_out_t    held;
    bit          have;
    logic        on0, on1, a, c, snd, knd;
    logic [1:0]  nd;
    logic [31:0] sp;
    have = 1'b0;
    held = '0;
    if (b.cmd == CMD_LOAD) begin
      nd = (b.node_init == NODE_RSVD) ? ND_DOWN : b.node_init;
      tbl_en[b.ring_slot]     = b.ring_enable;
      tbl_master[b.ring_slot] = b.node_is_master;
      tbl_pa[b.ring_slot]     = b.port_a_id;
      tbl_pb[b.ring_slot]     = b.port_b_id;
      tbl_sa[b.ring_slot]     = b.port_a_init;
      tbl_sb[b.ring_slot]     = b.port_b_init;
      tbl_node[b.ring_slot]   = nd;
      held.matched      = 1'b1;
      held.slot_out     = b.ring_slot;
      held.port_a_state = b.port_a_init;
      held.port_b_state = b.port_b_init;
      held.node_state   = nd;
    end else if ((b.cmd == CMD_UP || b.cmd == CMD_DOWN) && svc_en) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        on0 = tbl_en[i] && (b.event_port == tbl_pa[i]);
        on1 = tbl_en[i] && (b.event_port == tbl_pb[i]);
        if (on0 || on1) begin
          a   = tbl_sa[i];
          c   = tbl_sb[i];
          nd  = tbl_node[i];
          snd = 1'b0;
          knd = PKT_FLUSH;
          sp  = '0;
          if (b.cmd == CMD_UP) begin
            if (a == ST_BLOCK && c == ST_BLOCK) begin
              if (!tbl_master[i]) nd = ND_PRE;
              else if (on0) a = ST_FWD;
              else c = ST_FWD;
            end else if (a == ST_FWD && c == ST_BLOCK) begin
              if (!on0 && !tbl_master[i]) nd = ND_PRE;
            end else if (a == ST_BLOCK && c == ST_FWD) begin
              if (on0) begin
                if (tbl_master[i]) begin
                  a = ST_FWD;
                  c = ST_BLOCK;
                end else begin
                  nd = ND_PRE;
                end
              end
            end else if (tbl_master[i]) begin
              a = ST_FWD;
              c = ST_BLOCK;
            end else begin
              nd = ND_PRE;
              a  = ST_BLOCK;
              c  = ST_BLOCK;
            end
          end else begin
            if (a == ST_FWD && c == ST_BLOCK) begin
              if (on0) begin
                a   = ST_BLOCK;
                snd = 1'b1;
                sp  = tbl_pb[i];
                if (tbl_master[i]) c = ST_FWD;
                else knd = PKT_LINK_DOWN;
              end else if (!tbl_master[i]) begin
                snd = 1'b1;
                knd = PKT_LINK_DOWN;
                sp  = tbl_pa[i];
              end
            end else if (a == ST_BLOCK && c == ST_FWD) begin
              if (!on0) begin
                c   = ST_BLOCK;
                snd = 1'b1;
                sp  = tbl_pa[i];
                if (!tbl_master[i]) begin
                  nd  = ND_DOWN;
                  knd = PKT_LINK_DOWN;
                end
              end
            end else if (a == ST_FWD && c == ST_FWD) begin
              // Port 0 wins when the event names both ports.
              snd = 1'b1;
              if (on0) begin
                sp = tbl_pb[i];
                a  = ST_BLOCK;
              end else begin
                sp = tbl_pa[i];
                c  = ST_BLOCK;
              end
              if (!tbl_master[i]) begin
                nd  = ND_DOWN;
                knd = PKT_LINK_DOWN;
              end
            end
          end
          tbl_sa[i]   = a;
          tbl_sb[i]   = c;
          tbl_node[i] = nd;
          // The previous match is now known not to be the final beat.
          if (have) report_fifo.push_back(held);
          held = '0;
          held.matched      = 1'b1;
          held.slot_out     = 5'(i);
          held.port_a_state = a;
          held.port_b_state = c;
          held.node_state   = nd;
          held.send_packet  = snd;
          held.packet_kind  = knd;
          held.send_port    = sp;
          have = 1'b1;
        end
      end
    end
    // With nothing matched, held is still all zero: the unmatched report.
    held.last = 1'b1;
    report_fifo.push_back(held);
  endtask

  function automatic logic [31:0] pick_port();
    if ($urandom_range(3) == 0) return $urandom;
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_0001;
      3: return 32'h8000_0000;
      4: return 32'h0000_1234;
      default: return 32'h5A5A_A5A5;
    endcase
  endfunction

  function automatic rpl_in_t random_beat();
    rpl_in_t     b;
    int unsigned pick;
    pick             = $urandom_range(99);
    b.cmd            = (pick < 40) ? CMD_LOAD : (pick < 70) ? CMD_UP :
                       (pick < 96) ? CMD_DOWN : CMD_RSVD;
    b.ring_slot      = 5'($urandom_range(SLOT_COUNT - 1));
    b.ring_enable    = ($urandom_range(99) < 85);
    b.node_is_master = 1'($urandom_range(1));
    b.port_a_id      = pick_port();
    b.port_b_id      = pick_port();
    b.port_a_init    = 1'($urandom_range(1));
    b.port_b_init    = 1'($urandom_range(1));
    b.node_init      = 2'($urandom_range(3));
    b.event_port     = pick_port();
    return b;
  endfunction

  function automatic rpl_in_t load_beat(logic [4:0] slot, logic en, logic mst,
                                        logic [31:0] pa, logic [31:0] pb,
                                        logic a, logic c, logic [1:0] nd);
    rpl_in_t b;
    b                = random_beat();
    b.cmd            = CMD_LOAD;
    b.ring_slot      = slot;
    b.ring_enable    = en;
    b.node_is_master = mst;
    b.port_a_id      = pa;
    b.port_b_id      = pb;
    b.port_a_init    = a;
    b.port_b_init    = c;
    b.node_init      = nd;
    return b;
  endfunction

  function automatic rpl_in_t event_beat(logic [1:0] cmd, logic [31:0] port);
    rpl_in_t b;
    b            = random_beat();
    b.cmd        = cmd;
    b.event_port = port;
    return b;
  endfunction

  task automatic queue_random(int unsigned count);
    repeat (count) cmd_fifo.push_back(random_beat());
  endtask

  task automatic drain();
    while (cmd_fifo.size() != 0 || report_fifo.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_service(logic value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    svc_en = value;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Command side: hold a beat until it is taken, otherwise idle at random.
  always @(negedge clk_i) begin
    if (!in_valid_i || beat_taken) begin
      if (cmd_fifo.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= cmd_fifo[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < dst_idle_pct);
  end

  always @(posedge clk_i) begin
    beat_taken = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      ring_rules(cmd_fifo.pop_front());
      beat_taken = 1'b1;
      beats_taken++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reports_seen++;
      if (out_data_o.matched === 1'b1) reports_matched++;
      if (report_fifo.size() == 0) begin
        errors++;
        $display("%0t: report beat with none expected, got %p", $time, out_data_o);
      end else begin
        want_report = report_fifo.pop_front();
        check_field("matched", 32'(want_report.matched), 32'(out_data_o.matched));
        check_field("slot_out", 32'(want_report.slot_out), 32'(out_data_o.slot_out));
        check_field("port_a_state", 32'(want_report.port_a_state),
                    32'(out_data_o.port_a_state));
        check_field("port_b_state", 32'(want_report.port_b_state),
                    32'(out_data_o.port_b_state));
        check_field("node_state", 32'(want_report.node_state),
                    32'(out_data_o.node_state));
        check_field("send_packet", 32'(want_report.send_packet),
                    32'(out_data_o.send_packet));
        check_field("packet_kind", 32'(want_report.packet_kind),
                    32'(out_data_o.packet_kind));
        check_field("send_port", want_report.send_port, out_data_o.send_port);
        check_field("last", 32'(want_report.last), 32'(out_data_o.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    svc_en       = 1'b0;
    src_idle_pct = 8;
    dst_idle_pct = 63;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the service off, an event must leave the table alone.
    cmd_fifo.push_back(load_beat(5'd9, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0042,
                                 ST_BLOCK, ST_BLOCK, ND_IDLE));
    cmd_fifo.push_back(event_beat(CMD_UP, 32'h0000_0000));
    drain();
    set_service(1'b1);
    @(posedge clk_i);

    cmd_fifo.push_back(load_beat(5'd9, 1'b0, 1'b1, 32'h0, 32'h42, ST_BLOCK, ST_BLOCK,
                                 ND_IDLE));
    cmd_fifo.push_back(event_beat(CMD_UP, 32'h0000_0005));
    cmd_fifo.push_back(load_beat(5'd0, 1'b1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF,
                                 ST_FWD, ST_BLOCK, ND_IDLE));
    cmd_fifo.push_back(load_beat(5'd31, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0005,
                                 ST_BLOCK, ST_FWD, NODE_RSVD));
    cmd_fifo.push_back(load_beat(5'd7, 1'b1, 1'b0, 32'h0000_0005, 32'h0000_0005,
                                 ST_FWD, ST_FWD, ND_PRE));
    cmd_fifo.push_back(load_beat(5'd12, 1'b0, 1'b1, 32'h0, 32'h0, ST_FWD, ST_FWD,
                                 ND_IDLE));
    cmd_fifo.push_back(event_beat(CMD_RSVD, 32'h0000_0000));
    cmd_fifo.push_back(event_beat(CMD_DOWN, 32'h0000_0000));
    cmd_fifo.push_back(event_beat(CMD_DOWN, 32'hFFFF_FFFF));
    cmd_fifo.push_back(event_beat(CMD_UP, 32'hFFFF_FFFF));
    cmd_fifo.push_back(event_beat(CMD_DOWN, 32'h0000_0005));
    cmd_fifo.push_back(event_beat(CMD_UP, 32'h0000_0005));
    cmd_fifo.push_back(load_beat(5'd3, 1'b1, 1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                 ST_FWD, ST_FWD, ND_DOWN));
    cmd_fifo.push_back(event_beat(CMD_UP, 32'h5A5A_5A5A));
    cmd_fifo.push_back(load_beat(5'd3, 1'b1, 1'b0, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                 ST_FWD, ST_FWD, ND_IDLE));
    cmd_fifo.push_back(event_beat(CMD_UP, 32'hA5A5_A5A5));
    cmd_fifo.push_back(load_beat(5'd20, 1'b1, 1'b0, 32'h11, 32'h22, ST_FWD, ST_BLOCK,
                                 ND_IDLE));
    cmd_fifo.push_back(event_beat(CMD_DOWN, 32'h22));
    cmd_fifo.push_back(event_beat(CMD_DOWN, 32'h11));
    cmd_fifo.push_back(load_beat(5'd21, 1'b1, 1'b0, 32'h33, 32'h44, ST_FWD, ST_BLOCK,
                                 ND_IDLE));
    cmd_fifo.push_back(event_beat(CMD_UP, 32'h44));
    cmd_fifo.push_back(event_beat(CMD_UP, 32'h33));
    cmd_fifo.push_back(load_beat(5'd22, 1'b1, 1'b1, 32'h66, 32'h99, ST_BLOCK, ST_FWD,
                                 ND_IDLE));
    cmd_fifo.push_back(event_beat(CMD_UP, 32'h66));
    cmd_fifo.push_back(load_beat(5'd23, 1'b1, 1'b1, 32'h88, 32'h99, ST_FWD, ST_FWD,
                                 ND_IDLE));
    cmd_fifo.push_back(event_beat(CMD_DOWN, 32'h99));
    drain();

    queue_random(136);
    drain();

    src_idle_pct = 63;
    dst_idle_pct = 8;
    set_service(1'b0);
    queue_random(50);
    drain();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    set_service(1'b1);
    queue_random(136);
    drain();
    repeat (40) @(posedge clk_i);

    $display("Sent %0d command beats over three idle patterns, service on and off.",
             beats_taken);
    $display("Checked %0d report beats, %0d of them for matching slots.",
             reports_seen, reports_matched);
    if (errors == 0 && report_fifo.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
